>>> hw/rtl/gfau_pkg.sv
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types and constants of the GF(2^m) arithmetic unit: request codes,
// datapath commands and the status word returned to the controller.
// ----------------------------------------------------------------------------
package gfau_pkg;

  localparam int unsigned FieldW = 64;
  localparam int unsigned OpW    = 3;

  localparam logic [OpW-1:0] OP_MUL = 3'd0;
  localparam logic [OpW-1:0] OP_POW = 3'd1;
  localparam logic [OpW-1:0] OP_RED = 3'd2;
  localparam logic [OpW-1:0] OP_INV = 3'd3;
  localparam logic [OpW-1:0] OP_DIV = 3'd4;
  localparam logic [OpW-1:0] OP_GCD = 3'd5;

  localparam logic [FieldW-1:0] ModulusReset = 64'd283;

  typedef enum logic [4:0] {
    C_NOP,
    C_LOAD,
    C_DEG,
    C_RED_A,
    C_RED_B,
    C_RED_STEP,
    C_SAVE_A,
    C_SAVE_B,
    C_MUL_AB,
    C_MUL_AS,
    C_MUL_RB,
    C_MUL_BB,
    C_MUL_STEP,
    C_SAVE_RES,
    C_SQ_SAVE,
    C_PW_INIT,
    C_EU_A,
    C_EU_B,
    C_EU_STEP,
    C_OUT_ACC,
    C_OUT_RES,
    C_OUT_S0,
    C_OUT_R0,
    C_OUT_ZERO
  } cmd_e;

  typedef struct packed {
    logic deg_stop;
    logic degenerate;
    logic red_last;
    logic mul_last;
    logic e_zero;
    logic e_lsb;
    logic r1_zero;
    logic gcd_one;
  } status_t;

endpackage

>>> hw/rtl/gfau_dpath.sv
// ----------------------------------------------------------------------------
// gfau_dpath
// Datapath: modulus degree search, bit-serial reduction, shift-and-add field
// multiplier, exponent register and one extended Euclid step per cycle.
// ----------------------------------------------------------------------------
module gfau_dpath import gfau_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic              clk_i,
  input  cmd_e              cmd_i,
  input  logic [FieldW-1:0] modulus_i,
  input  logic [FieldW-1:0] operand_a_i,
  input  logic [FieldW-1:0] operand_b_i,
  output status_t           status_o,
  output logic [FieldW-1:0] result_o
);

  localparam int unsigned IW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] m_q, a_q, b_q, acc_q, x_q, y_q;
  logic [WORD_BITS-1:0] base_q, res_q, e_q, result_q;
  logic [WORD_BITS-1:0] r0_q, r1_q, s0_q, s1_q;
  logic [IW-1:0]        dg_q, i_q, d0_q, d1_q;

  logic [WORD_BITS-1:0] red_d, mul_d, r0x, s0x;
  logic [IW-1:0]        eu_sh;

  always_comb begin
    red_d = acc_q[i_q] ? (acc_q ^ (m_q << (i_q - dg_q))) : acc_q;
    mul_d = acc_q << 1;
    if (mul_d[dg_q]) begin
      mul_d = mul_d ^ m_q;
    end
    if (x_q[i_q]) begin
      mul_d = mul_d ^ y_q;
    end
    eu_sh = d0_q - d1_q;
    r0x   = r0_q[d0_q] ? (r0_q ^ (r1_q << eu_sh)) : r0_q;
    s0x   = r0_q[d0_q] ? (s0_q ^ (s1_q << eu_sh)) : s0_q;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_LOAD: begin
        m_q  <= modulus_i[WORD_BITS-1:0];
        a_q  <= operand_a_i[WORD_BITS-1:0];
        b_q  <= operand_b_i[WORD_BITS-1:0];
        dg_q <= IW'(WORD_BITS - 1);
      end
      C_DEG: begin
        if (!(m_q[dg_q] || dg_q == '0)) begin
          dg_q <= dg_q - 1'b1;
        end
      end
      C_RED_A: begin
        acc_q <= a_q;
        i_q   <= IW'(WORD_BITS - 1);
      end
      C_RED_B: begin
        acc_q <= b_q;
        i_q   <= IW'(WORD_BITS - 1);
      end
      C_RED_STEP: begin
        acc_q <= red_d;
        if (i_q != dg_q) begin
          i_q <= i_q - 1'b1;
        end
      end
      C_SAVE_A: a_q <= acc_q;
      C_SAVE_B: b_q <= acc_q;
      C_MUL_AB, C_MUL_AS, C_MUL_RB, C_MUL_BB: begin
        acc_q <= '0;
        i_q   <= dg_q - 1'b1;
        case (cmd_i)
          C_MUL_AB: begin
            x_q <= a_q;
            y_q <= b_q;
          end
          C_MUL_AS: begin
            x_q <= a_q;
            y_q <= s0_q;
          end
          C_MUL_RB: begin
            x_q <= res_q;
            y_q <= base_q;
          end
          default: begin
            x_q <= base_q;
            y_q <= base_q;
          end
        endcase
      end
      C_MUL_STEP: begin
        acc_q <= mul_d;
        if (i_q != '0) begin
          i_q <= i_q - 1'b1;
        end
      end
      C_SAVE_RES: res_q <= acc_q;
      C_SQ_SAVE: begin
        base_q <= acc_q;
        e_q    <= e_q >> 1;
      end
      C_PW_INIT: begin
        res_q  <= WORD_BITS'(1);
        base_q <= a_q;
        e_q    <= b_q;
      end
      C_EU_A, C_EU_B: begin
        r0_q <= m_q;
        r1_q <= (cmd_i == C_EU_B) ? b_q : a_q;
        s0_q <= '0;
        s1_q <= WORD_BITS'(1);
        d0_q <= dg_q;
        d1_q <= dg_q - 1'b1;
      end
      C_EU_STEP: begin
        if (!r1_q[d1_q]) begin
          d1_q <= d1_q - 1'b1;
        end else if (d0_q == d1_q) begin
          r0_q <= r1_q;
          r1_q <= r0x;
          s0_q <= s1_q;
          s1_q <= s0x;
          d0_q <= d1_q;
          d1_q <= (d1_q == '0) ? '0 : d1_q - 1'b1;
        end else begin
          r0_q <= r0x;
          s0_q <= s0x;
          d0_q <= d0_q - 1'b1;
        end
      end
      C_OUT_ACC:  result_q <= acc_q;
      C_OUT_RES:  result_q <= res_q;
      C_OUT_S0:   result_q <= s0_q;
      C_OUT_R0:   result_q <= r0_q;
      C_OUT_ZERO: result_q <= '0;
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.deg_stop   = m_q[dg_q] || (dg_q == '0);
    status_o.degenerate = (dg_q == '0);
    status_o.red_last   = (i_q == dg_q);
    status_o.mul_last   = (i_q == '0);
    status_o.e_zero     = (e_q == '0);
    status_o.e_lsb      = e_q[0];
    status_o.r1_zero    = (r1_q == '0);
    status_o.gcd_one    = (r0_q == WORD_BITS'(1));
  end

  assign result_o = FieldW'(result_q);

endmodule

>>> hw/rtl/gfau_ctrl.sv
// ----------------------------------------------------------------------------
// gfau_ctrl
// Controller: sequences the datapath commands for each request code and
// produces the busy, done and error signals.
// ----------------------------------------------------------------------------
module gfau_ctrl import gfau_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [OpW-1:0] op_i,
  input  status_t        status_i,
  output cmd_e           cmd_o,
  output logic           busy_o,
  output logic           done_o,
  output logic           err_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEG      = 4'd1;
  localparam logic [3:0] S_RED_INIT = 4'd2;
  localparam logic [3:0] S_RED_STEP = 4'd3;
  localparam logic [3:0] S_RED_SAVE = 4'd4;
  localparam logic [3:0] S_EU_INIT  = 4'd5;
  localparam logic [3:0] S_EU_STEP  = 4'd6;
  localparam logic [3:0] S_MUL_INIT = 4'd7;
  localparam logic [3:0] S_MUL_STEP = 4'd8;
  localparam logic [3:0] S_MUL_DONE = 4'd9;
  localparam logic [3:0] S_PW_INIT  = 4'd10;
  localparam logic [3:0] S_PW_CHECK = 4'd11;

  logic [3:0]     state_q, state_d;
  logic [OpW-1:0] op_q, op_d;
  logic           redb_q, redb_d, sq_q, sq_d, done_q, done_d, err_q, err_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    redb_d  = redb_q;
    sq_d    = sq_q;
    done_d  = 1'b0;
    err_d   = 1'b0;
    cmd_o   = C_NOP;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = C_LOAD;
          op_d    = op_i;
          state_d = S_DEG;
        end
      end
      S_DEG: begin
        if (!status_i.deg_stop) begin
          cmd_o = C_DEG;
        end else if (status_i.degenerate || op_q > OP_GCD) begin
          cmd_o   = C_OUT_ZERO;
          done_d  = 1'b1;
          err_d   = status_i.degenerate && (op_q inside {OP_INV, OP_DIV});
          state_d = S_IDLE;
        end else begin
          redb_d  = 1'b0;
          state_d = S_RED_INIT;
        end
      end
      S_RED_INIT: begin
        cmd_o   = redb_q ? C_RED_B : C_RED_A;
        state_d = S_RED_STEP;
      end
      S_RED_STEP: begin
        cmd_o = C_RED_STEP;
        if (status_i.red_last) begin
          state_d = S_RED_SAVE;
        end
      end
      S_RED_SAVE: begin
        cmd_o = redb_q ? C_SAVE_B : C_SAVE_A;
        if (redb_q) begin
          state_d = (op_q == OP_DIV) ? S_EU_INIT : S_MUL_INIT;
        end else if (op_q inside {OP_MUL, OP_DIV}) begin
          redb_d  = 1'b1;
          state_d = S_RED_INIT;
        end else if (op_q == OP_POW) begin
          state_d = S_PW_INIT;
        end else if (op_q == OP_RED) begin
          cmd_o   = C_OUT_ACC;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_EU_INIT;
        end
      end
      S_EU_INIT: begin
        cmd_o   = (op_q == OP_DIV) ? C_EU_B : C_EU_A;
        state_d = S_EU_STEP;
      end
      S_EU_STEP: begin
        if (!status_i.r1_zero) begin
          cmd_o = C_EU_STEP;
        end else if (op_q == OP_GCD) begin
          cmd_o   = C_OUT_R0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (!status_i.gcd_one) begin
          cmd_o   = C_OUT_ZERO;
          done_d  = 1'b1;
          err_d   = 1'b1;
          state_d = S_IDLE;
        end else if (op_q == OP_DIV) begin
          state_d = S_MUL_INIT;
        end else begin
          cmd_o   = C_OUT_S0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MUL_INIT: begin
        if (op_q == OP_MUL) begin
          cmd_o = C_MUL_AB;
        end else if (op_q == OP_DIV) begin
          cmd_o = C_MUL_AS;
        end else begin
          cmd_o = sq_q ? C_MUL_BB : C_MUL_RB;
        end
        state_d = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        cmd_o = C_MUL_STEP;
        if (status_i.mul_last) begin
          state_d = S_MUL_DONE;
        end
      end
      S_MUL_DONE: begin
        if (op_q != OP_POW) begin
          cmd_o   = C_OUT_ACC;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (!sq_q) begin
          cmd_o   = C_SAVE_RES;
          sq_d    = 1'b1;
          state_d = S_MUL_INIT;
        end else begin
          cmd_o   = C_SQ_SAVE;
          state_d = S_PW_CHECK;
        end
      end
      S_PW_INIT: begin
        cmd_o   = C_PW_INIT;
        state_d = S_PW_CHECK;
      end
      S_PW_CHECK: begin
        if (status_i.e_zero) begin
          cmd_o   = C_OUT_RES;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          sq_d    = !status_i.e_lsb;
          state_d = S_MUL_INIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_MUL;
      redb_q  <= 1'b0;
      sq_q    <= 1'b0;
      done_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      redb_q  <= redb_d;
      sq_q    <= sq_d;
      done_q  <= done_d;
      err_q   <= err_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign err_o  = err_q;

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != S_IDLE))
    else $error("done without a request in progress");
  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> done_q)
    else $error("error flag outside a result word");
  a_idle_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> !done_q)
    else $error("done raised from idle");
  a_err_only_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (op_q == OP_INV || op_q == OP_DIV))
    else $error("error flag on an operation that cannot fail");
`endif

endmodule

>>> hw/rtl/gf2m_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf2m_arithmetic_unit
// GF(2)[x] arithmetic modulo a programmable polynomial: multiply, power,
// reduce, inverse, divide and gcd with the modulus.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result word
// appears on result_value_o and not_invertible_o for exactly one cycle with
// done_o high, and must be captured then. Requests run one at a time. Each
// starts with a degree search of the modulus; for a valid request code and a
// modulus of nonzero degree, a one-bit-per-cycle reduction of operand a
// follows, and of operand b for multiply and divide. A field multiply runs
// in the shift-and-add unit; power runs up to two multiplies per exponent
// bit. Inverse, divide and gcd run one extended Euclid step per cycle, and
// divide adds one field multiply. The modulus may be written through the
// configuration channel whenever busy is low.
// ----------------------------------------------------------------------------
module gf2m_arithmetic_unit import gfau_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OpW-1:0]    req_type_i,
  input  logic [FieldW-1:0] operand_a_i,
  input  logic [FieldW-1:0] operand_b_i,
  output logic              done_o,
  output logic [FieldW-1:0] result_value_o,
  output logic              not_invertible_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [FieldW-1:0] cfg_data_i
);

  logic [FieldW-1:0] modulus_q;
  cmd_e              cmd;
  status_t           status;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      modulus_q <= cfg_data_i;
    end
  end

  gfau_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (req_type_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o),
    .err_o    (not_invertible_o)
  );

  gfau_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .modulus_i   (modulus_q),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .status_o    (status),
    .result_o    (result_value_o)
  );

endmodule

>>> tb/tb_gf2m_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_gf2m_arithmetic_unit
// Self-checking testbench for the GF(2)[x] arithmetic unit. Requests are
// driven through the start/busy handshake under several moduli, and every
// result word is compared against a behavioral predictor of the field math.
// ----------------------------------------------------------------------------
module tb_gf2m_arithmetic_unit;
  import gfau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FieldW-1:0] value;
    logic              no_inverse;
  } gf_word_t;

  class gf_scoreboard;
    gf_word_t    pending_q[$];
    logic [63:0] modulus;
    int          mismatches;

    function new();
      modulus    = ModulusReset;
      mismatches = 0;
    endfunction

    function int degree(logic [63:0] v);
      for (int i = 63; i >= 0; i--) if (v[i]) return i;
      return -1;
    endfunction

    function logic [63:0] remainder(logic [63:0] v, int d);
      for (int i = 63; i >= d; i--) if (v[i]) v ^= modulus << (i - d);
      return v;
    endfunction

    function logic [63:0] field_mul(logic [63:0] a, logic [63:0] b, int d);
      logic [63:0] acc;
      acc = '0;
      for (int i = d - 1; i >= 0; i--) begin
        acc = acc << 1;
        if (acc[d]) acc ^= modulus;
        if (a[i]) acc ^= b;
      end
      return acc;
    endfunction

    function logic [63:0] euclid(logic [63:0] x, output logic [63:0] coef);
      logic [63:0] r0, r1, s0, s1, t;
      int d0, d1;
      r0 = modulus;
      r1 = x;
      s0 = '0;
      s1 = 64'd1;
      while (r1 != '0) begin
        d1 = degree(r1);
        d0 = degree(r0);
        while (d0 >= d1) begin
          r0 ^= r1 << (d0 - d1);
          s0 ^= s1 << (d0 - d1);
          d0 = degree(r0);
        end
        t = r0; r0 = r1; r1 = t;
        t = s0; s0 = s1; s1 = t;
      end
      coef = s0;
      return r0;
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [63:0] a, logic [63:0] b);
      gf_word_t    w;
      logic [63:0] base, e, inv;
      int d;
      w = '0;
      d = degree(modulus);
      if (d < 1) begin
        w.no_inverse = (op == OP_INV) || (op == OP_DIV);
      end else begin
        case (op)
          OP_MUL: w.value = field_mul(remainder(a, d), remainder(b, d), d);
          OP_POW: begin
            base    = remainder(a, d);
            w.value = 64'd1;
            for (e = b; e != '0; e = e >> 1) begin
              if (e[0]) w.value = field_mul(w.value, base, d);
              base = field_mul(base, base, d);
            end
          end
          OP_RED: w.value = remainder(a, d);
          OP_INV: begin
            if (euclid(remainder(a, d), inv) == 64'd1) w.value = inv;
            else w.no_inverse = 1'b1;
          end
          OP_DIV: begin
            if (euclid(remainder(b, d), inv) == 64'd1)
              w.value = field_mul(remainder(a, d), inv, d);
            else w.no_inverse = 1'b1;
          end
          OP_GCD: w.value = euclid(remainder(a, d), inv);
          default: ;
        endcase
      end
      pending_q.push_back(w);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_word(logic [63:0] value, logic no_inverse);
      gf_word_t w;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word %h", value));
        return;
      end
      w = pending_q.pop_front();
      if (value !== w.value)
        report($sformatf("result_value %h, predicted %h", value, w.value));
      if (no_inverse !== w.no_inverse)
        report($sformatf("not_invertible %b, predicted %b", no_inverse, w.no_inverse));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [OpW-1:0]    req_type_i;
  logic [FieldW-1:0] operand_a_i;
  logic [FieldW-1:0] operand_b_i;
  logic              done_o;
  logic [FieldW-1:0] result_value_o;
  logic              not_invertible_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [FieldW-1:0] cfg_data_i;

  gf_scoreboard sb;
  bit           calm;

  gf2m_arithmetic_unit i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_type_i,
    .operand_a_i,
    .operand_b_i,
    .done_o,
    .result_value_o,
    .not_invertible_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_word(result_value_o, not_invertible_o);
  end

  task automatic send_request(logic [OpW-1:0] op, logic [63:0] a, logic [63:0] b);
    if (!calm && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 18)) @(negedge clk_i);
    @(negedge clk_i);
    start       = 1'b1;
    req_type_i  = op;
    operand_a_i = a;
    operand_b_i = b;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_request(op, a, b);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_modulus(logic [63:0] m);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = m;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.modulus = m;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_requests(int n, int d);
    logic [63:0] a, b, mask;
    logic [OpW-1:0] op;
    mask = (d >= 63) ? '1 : ((64'd1 << (d + 1)) - 1);
    for (int i = 0; i < n; i++) begin
      op = OpW'($urandom_range(OP_MUL, OP_GCD));
      a  = {$urandom, $urandom};
      b  = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
        a &= mask;
        b &= mask;
      end
      if (op == OP_POW && $urandom_range(0, 9) != 0) b = 64'($urandom_range(0, 255));
      if (i == n / 2 && $urandom_range(0, 1) == 0) drain();
      send_request(op, a, b);
    end
  endtask

  initial begin
    logic [63:0] m;
    sb          = new();
    calm        = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type_i  = OP_MUL;
    operand_a_i = '0;
    operand_b_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(OP_MUL, '1, '1);
    send_request(OP_MUL, 64'h57, 64'h83);
    send_request(OP_MUL, '0, 64'h1F);
    send_request(OP_POW, 64'h3, '0);
    send_request(OP_POW, 64'h3, '1);
    send_request(OP_POW, '0, 64'd5);
    send_request(OP_RED, '1, '0);
    send_request(OP_RED, 64'h11B, '0);
    send_request(OP_INV, '0, '0);
    send_request(OP_INV, 64'd1, '0);
    send_request(OP_INV, 64'h53, '0);
    send_request(OP_INV, 64'h11B, '0);
    send_request(OP_DIV, 64'hCA, '0);
    send_request(OP_DIV, '1, 64'h53);
    send_request(OP_GCD, '0, '0);
    send_request(OP_GCD, 64'h1F, '0);
    random_requests(10, 8);

    write_modulus(64'd3);
    send_request(OP_INV, 64'd1, '0);
    send_request(OP_DIV, '1, '1);
    send_request(OP_GCD, 64'd2, '0);
    random_requests(10, 1);

    write_modulus(64'h8000_0000_0000_001B);
    send_request(OP_POW, '1, '1);
    send_request(OP_DIV, '1, 64'hAAAA_5555_0F0F_F0F0);
    random_requests(20, 63);

    write_modulus('1);
    send_request(OP_INV, '1, '0);
    random_requests(15, 63);

    for (int k = 0; k < 3; k++) begin
      m = {$urandom, $urandom};
      m = (m >> $urandom_range(1, 60)) | 64'd3;
      write_modulus(m);
      random_requests(10, sb.degree(m));
    end

    write_modulus(ModulusReset);
    calm = 1'b1;
    random_requests(15, 8);

    drain();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
